// ===== rtl/ssbs_pkg.sv =====
package ssbs_pkg;

  localparam int ITEM_W  = 11;
  localparam int PROD_W  = 19;
  localparam int WORD_W  = 32;
  localparam int WORD_SH = 5;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL,
    ST_PRIME,
    ST_ADD,
    ST_DRAIN,
    ST_END,
    ST_SRCH_RD,
    ST_SRCH_CHK,
    ST_MUL,
    ST_RESULT
  } ssbs_state_t;

  typedef struct packed {
    logic clear_start;
    logic clear_step;
    logic take;
    logic eval;
    logic prime;
    logic add_step;
    logic srch_start;
    logic srch_chk;
    logic mul;
    logic load_out;
  } ssbs_cmd_t;

  typedef struct packed {
    logic add_ok;
    logic last;
    logic ovf;
    logic cnt_zero;
    logic found;
    logic out_free;
  } ssbs_status_t;

endpackage

// ===== rtl/ssbs_if.sv =====
interface ssbs_item_if import ssbs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ITEM_W-1:0] item_value;
  logic              last_item;

  modport source (output valid, output item_value, output last_item, input ready);
  modport sink   (input valid, input item_value, input last_item, output ready);
endinterface

interface ssbs_result_if import ssbs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PROD_W-1:0] split_product;
  logic              overflow;

  modport source (output valid, output split_product, output overflow, input ready);
  modport sink   (input valid, input split_product, input overflow, output ready);
endinterface

// ===== rtl/subset_sum_balanced_split_core.sv =====
// Balanced split of a set of small integers.
// items   : one beat per set element (item_value, last_item marks the final one).
// results : one beat per set, after its last item: split_product is the best
//           i*(total-i) over reachable subset sums i <= total/2, overflow is set
//           (with a zero product) when the set total passed MAX_SUM.
// The reachable-sum bitset lives in a memory of NW = MAX_SUM/32+1 words of 32
// bits. Each nonzero item that fits under MAX_SUM walks every word once from
// the top down, OR-ing in the bitset shifted up by the item value, two reads
// and one write per cycle. A zero item, one that would take the total past
// MAX_SUM or one in an overflowed set skips the walk. items.ready is high only
// between items. After the last item the search reads and then checks one word
// at a time, from word total/64 downwards, then multiplies. The result then
// sits in an output register; a stalled receiver holds it there and the block
// waits only if a further result is ready before the previous beat is taken.
// After each result, and after reset, a clearing pass over all NW words writes
// the bitset back to only sum zero; items.ready stays low meanwhile.
// Reset (rst, synchronous) drops results.valid and starts that clearing pass.
module subset_sum_balanced_split_core import ssbs_pkg::*; #(
  parameter int MAX_SUM = 1024
) (
  input logic           clk,
  input logic           rst,
  ssbs_item_if.sink     items,
  ssbs_result_if.source results
);

  ssbs_cmd_t    cmd;
  ssbs_status_t status;

  // sequencer: one state per step of the add, search and clear sweeps
  ssbs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (items.valid),
    .in_ready (items.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // bitset memory, totals, search and multiply, output register
  ssbs_dp #(
    .MAX_SUM (MAX_SUM)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_value  (items.item_value),
    .in_last   (items.last_item),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_split (results.split_product),
    .out_ovf   (results.overflow)
  );

endmodule

// ===== rtl/ssbs_ctrl.sv =====
module ssbs_ctrl import ssbs_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  ssbs_status_t status,
  output ssbs_cmd_t    cmd
);

  ssbs_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.cnt_zero) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = status.add_ok ? ST_PRIME : ST_END;
      end
      ST_PRIME: begin
        cmd.prime  = 1'b1;
        state_next = ST_ADD;
      end
      ST_ADD: begin
        cmd.add_step = 1'b1;
        if (status.cnt_zero) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_next = ST_END;
      end
      ST_END: begin
        if (!status.last) begin
          state_next = ST_IDLE;
        end else if (status.ovf) begin
          state_next = ST_RESULT;
        end else begin
          cmd.srch_start = 1'b1;
          state_next     = ST_SRCH_RD;
        end
      end
      ST_SRCH_RD: begin
        state_next = ST_SRCH_CHK;
      end
      ST_SRCH_CHK: begin
        cmd.srch_chk = 1'b1;
        state_next   = status.found ? ST_MUL : ST_SRCH_RD;
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (status.out_free) begin
          cmd.load_out    = 1'b1;
          cmd.clear_start = 1'b1;
          state_next      = ST_CLEAR;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  // a finished sweep must always pass through the clearing pass before new items
  assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> state == ST_CLEAR)
    else $error("result loaded without clearing pass");

  assert property (@(posedge clk) disable iff (rst)
    $fell(state == ST_ADD) |-> $past(status.cnt_zero))
    else $error("add sweep left before word zero");

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_SRCH_CHK) |-> $past(state == ST_SRCH_RD))
    else $error("search check without a read");

endmodule

// ===== rtl/ssbs_dp.sv =====
module ssbs_dp import ssbs_pkg::*; #(
  parameter int MAX_SUM = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  ssbs_cmd_t         cmd,
  output ssbs_status_t      status,
  input  logic [ITEM_W-1:0] in_value,
  input  logic              in_last,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [PROD_W-1:0] out_split,
  output logic              out_ovf
);

  localparam int NW = (MAX_SUM >> WORD_SH) + 1;
  localparam int IW = (NW > 1) ? $clog2(NW) : 1;
  localparam int TW = $clog2(MAX_SUM + 1);
  localparam int CW = ((TW > ITEM_W) ? TW : ITEM_W) + 1;
  localparam int PW = 2 * TW;
  localparam logic [IW-1:0] TOP = IW'(NW - 1);

  logic [WORD_W-1:0] mem [NW];

  logic [ITEM_W-1:0] v_q;
  logic              last_q;
  logic [TW-1:0]     total;
  logic              ovf;
  logic [IW-1:0]     cnt;

  logic [WORD_W-1:0] rd_a, rd_b, prev_b;
  logic              rb_zero;
  logic              comp_v;
  logic [IW-1:0]     comp_addr;
  logic              first;
  logic [TW-1:0]     found_i;
  logic [PW-1:0]     prod;

  logic [IW-1:0]        d;
  logic [WORD_SH-1:0]   off;
  logic [IW-1:0]        rb_base;
  logic signed [IW+1:0] rb_idx;
  logic [IW-1:0]        rb_addr;
  logic [WORD_W-1:0]    rd_b_eff;
  logic [2*WORD_W-1:0]  pair;
  logic [WORD_W-1:0]    comp_word;
  logic                 wr_en;
  logic [IW-1:0]        wr_addr;
  logic [WORD_W-1:0]    wr_data;
  logic [TW-1:0]        half;
  logic [WORD_W-1:0]    mask, masked;
  logic [WORD_SH-1:0]   pos;
  logic                 found;
  logic [PW-1:0]        mul_a, mul_b;
  logic                 add_ok;

  // item offset in words and bits
  assign d   = IW'(v_q >> WORD_SH);
  assign off = WORD_SH'(v_q);

  assign add_ok = !ovf && (v_q != '0) &&
                  (CW'(v_q) <= CW'(MAX_SUM) - CW'(total));

  // low source word of the shifted window; the prime read fetches the top high word
  assign rb_base  = cmd.prime ? TOP : cnt;
  assign rb_idx   = $signed({2'b00, rb_base}) - $signed({2'b00, d}) -
                    $signed({{(IW+1){1'b0}}, !cmd.prime});
  assign rb_addr  = rb_idx[IW-1:0];
  assign rd_b_eff = rb_zero ? '0 : rd_b;

  assign pair      = {prev_b, rd_b_eff} << off;
  assign comp_word = rd_a | pair[2*WORD_W-1:WORD_W];

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = comp_addr;
    wr_data = comp_word;
    if (comp_v) begin
      wr_en = 1'b1;
    end else if (cmd.clear_step) begin
      wr_en   = 1'b1;
      wr_addr = cnt;
      wr_data = (cnt == '0) ? WORD_W'(1) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_a    <= mem[cnt];
    rd_b    <= mem[rb_addr];
    rb_zero <= rb_idx[IW+1];
    prev_b  <= rd_b_eff;
  end

  // search: highest set bit not above total/2
  assign half   = total >> 1;
  assign mask   = first ? ~({WORD_W{1'b1}} << 1 << WORD_SH'(half)) : '1;
  assign masked = rd_a & mask;
  assign found  = |masked;

  always_comb begin
    pos = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (masked[i]) pos = WORD_SH'(i);
    end
  end

  assign mul_a = PW'(found_i);
  assign mul_b = PW'(total - found_i);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= TOP;
      total     <= '0;
      ovf       <= 1'b0;
      comp_v    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      comp_v <= cmd.add_step;
      if (cmd.clear_start || cmd.prime) begin
        cnt <= TOP;
      end else if (cmd.clear_step || cmd.add_step) begin
        cnt <= cnt - IW'(1);
      end else if (cmd.srch_start) begin
        cnt <= IW'(half >> WORD_SH);
      end else if (cmd.srch_chk && !found) begin
        cnt <= cnt - IW'(1);
      end
      if (cmd.clear_start) begin
        total <= '0;
        ovf   <= 1'b0;
      end else if (cmd.eval) begin
        if (add_ok) begin
          total <= total + TW'(v_q);
        end else if (!ovf && (v_q != '0)) begin
          ovf <= 1'b1;
        end
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      v_q    <= in_value;
      last_q <= in_last;
    end
    if (cmd.add_step) comp_addr <= cnt;
    if (cmd.srch_start) begin
      first <= 1'b1;
    end else if (cmd.srch_chk) begin
      first <= 1'b0;
    end
    if (cmd.srch_chk && found) found_i <= TW'({cnt, pos});
    if (cmd.mul) prod <= mul_a * mul_b;
    if (cmd.load_out) begin
      out_split <= ovf ? '0 : PROD_W'(prod);
      out_ovf   <= ovf;
    end
  end

  assign status.add_ok   = add_ok;
  assign status.last     = last_q;
  assign status.ovf      = ovf;
  assign status.cnt_zero = (cnt == '0);
  assign status.found    = found;
  assign status.out_free = !out_valid || out_ready;

  assert property (@(posedge clk) disable iff (rst)
    total <= TW'(MAX_SUM))
    else $error("running total past maximum sum");

  // sum zero is always reachable, so the search ends at word zero at the latest
  assert property (@(posedge clk) disable iff (rst)
    (cmd.srch_chk && (cnt == '0)) |-> found)
    else $error("search ran past word zero");

  assert property (@(posedge clk) disable iff (rst)
    cmd.mul |-> (found_i <= half))
    else $error("chosen sum above half the total");

  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.load_out))
    else $error("result raised without a load");

endmodule
